### rtl/mpool_pkg.sv
// Shared types and constants for the int8 max pooling block.
// No dependencies; imported by max_pool_2d_int8, mpool_cfg and mpool_ctrl.
package mpool_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam int POS_W      = 12;
	localparam int WIN_CNT_W  = 5;

	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd7;

	localparam logic        FUNC_LOAD  = 1'b0;
	localparam logic        FUNC_QUERY = 1'b1;

	localparam logic signed [7:0] MAX_FLOOR = -8'sd128;

	typedef struct packed {
		logic [5:0] in_height;
		logic [5:0] in_width;
		logic [3:0] window_height;
		logic [3:0] window_width;
		logic [3:0] step_rows;
		logic [3:0] step_cols;
		logic [2:0] pad_rows;
		logic [2:0] pad_cols;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		in_height:     6'd32,
		in_width:      6'd32,
		window_height: 4'd2,
		window_width:  4'd2,
		step_rows:     4'd2,
		step_cols:     4'd2,
		pad_rows:      3'd0,
		pad_cols:      3'd0
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} mpool_state_t;

endpackage

### rtl/max_pool_2d_int8.sv
// Top level of the signed 8-bit 2D max pooling block over an HWC feature map.
// Depends on mpool_pkg, mpool_cfg, mpool_store and mpool_ctrl.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   func = load writes load_value at (load_row, load_col, load_channel) and
//   busy stays low, so loads may be issued every cycle while no query runs.
//   func = query scans the pool window of (out_row, out_col, out_channel),
//   one store read per cycle over all window_height*window_width positions,
//   each dimension capped at MAX_WINDOW and a zero one counted as one,
//   in bounds or not. busy stays high through the scan and the drain state;
//   done pulses for one cycle with max_value in the first cycle that busy
//   is low again; the single read port of the store paces the scan.
//   done is a one-cycle strobe; the receiver cannot hold it off.
//   Configuration: cfg_wr_en, cfg_index, cfg_data write register cfg_index
//   at once; write only while busy is low and no done is pending.
//   Reset returns the registers to 32, 32, 2, 2, 2, 2, 0, 0 and the
//   sequencer to idle; store contents are undefined until loaded.
module max_pool_2d_int8 #(
	parameter int MAX_ROWS     = 32,
	parameter int MAX_COLS     = 32,
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_WINDOW   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [4:0]                        load_row,
	input  logic [4:0]                        load_col,
	input  logic [3:0]                        load_channel,
	input  logic signed [7:0]                 load_value,
	input  logic [5:0]                        out_row,
	input  logic [5:0]                        out_col,
	input  logic [3:0]                        out_channel,
	output logic                              done,
	output logic signed [7:0]                 max_value,
	input  logic                              cfg_wr_en,
	input  logic [mpool_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpool_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mpool_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ADDR_W = RW + CW + HW;

	cfg_t              cfg;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]        wr_data, rd_data;

	mpool_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mpool_store #(
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mpool_ctrl #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_COLS     (MAX_COLS),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_WINDOW   (MAX_WINDOW),
		.ADDR_W       (ADDR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.load_row     (load_row),
		.load_col     (load_col),
		.load_channel (load_channel),
		.load_value   (load_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_channel  (out_channel),
		.done         (done),
		.max_value    (max_value),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

endmodule

### rtl/mpool_cfg.sv
// Configuration register file of the max pooling block.
// Depends on mpool_pkg for the register indexes and the cfg_t layout.
module mpool_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mpool_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpool_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mpool_pkg::cfg_t                   cfg
);
	import mpool_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IN_HEIGHT:     cfg_q.in_height     <= cfg_data;
				REG_IN_WIDTH:      cfg_q.in_width      <= cfg_data;
				REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data[3:0];
				REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data[3:0];
				REG_STEP_ROWS:     cfg_q.step_rows     <= cfg_data[3:0];
				REG_STEP_COLS:     cfg_q.step_cols     <= cfg_data[3:0];
				REG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data[2:0];
				REG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data[2:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/mpool_store.sv
// Feature map store: one write port and one read port, read data registered.
// No package dependency; depth follows from ADDR_W.
module mpool_store #(
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/mpool_ctrl.sv
// Request decode, window scan sequencer and running maximum.
// Depends on mpool_pkg; drives the ports of mpool_store.
module mpool_ctrl #(
	parameter int MAX_ROWS     = 32,
	parameter int MAX_COLS     = 32,
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_WINDOW   = 8,
	parameter int ADDR_W       = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mpool_pkg::cfg_t    cfg,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [4:0]         load_row,
	input  logic [4:0]         load_col,
	input  logic [3:0]         load_channel,
	input  logic signed [7:0]  load_value,
	input  logic [5:0]         out_row,
	input  logic [5:0]         out_col,
	input  logic [3:0]         out_channel,
	output logic               done,
	output logic signed [7:0]  max_value,
	output logic               wr_en,
	output logic [ADDR_W-1:0]  wr_addr,
	output logic [7:0]         wr_data,
	output logic               rd_en,
	output logic [ADDR_W-1:0]  rd_addr,
	input  logic [7:0]         rd_data
);
	import mpool_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int WI = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	mpool_state_t state_q, state_d;

	logic                 accept;
	logic                 load_ok;
	logic [7:0]           row8, col8, ch8, och8;
	logic [POS_W-1:0]     r0_q, c0_q;
	logic [3:0]           och_q;
	logic                 chan_ok_q;
	logic [WI-1:0]        i_q, j_q;
	logic [5:0]           hsat, wsat;
	logic [WIN_CNT_W-1:0] wh_sat, ww_sat;
	logic [POS_W-1:0]     row_pos, col_pos;
	logic                 pos_ok, last_pos, j_last;
	logic                 rd_ok_s1, last_s1;
	logic signed [7:0]    best_q, max_q;
	logic                 greater;
	logic                 done_q;

	assign accept = start && !busy;

	assign row8 = {3'b000, load_row};
	assign col8 = {3'b000, load_col};
	assign ch8  = {4'b0000, load_channel};
	assign load_ok = (9'(load_row) < 9'(MAX_ROWS)) && (9'(load_col) < 9'(MAX_COLS))
		&& (9'(load_channel) < 9'(MAX_CHANNELS));

	assign wr_en   = accept && (func == FUNC_LOAD) && load_ok;
	assign wr_addr = {row8[RW-1:0], col8[CW-1:0], ch8[HW-1:0]};
	assign wr_data = load_value;

	assign hsat = ({3'b000, cfg.in_height} > 9'(MAX_ROWS)) ? 6'(MAX_ROWS) : cfg.in_height;
	assign wsat = ({3'b000, cfg.in_width} > 9'(MAX_COLS)) ? 6'(MAX_COLS) : cfg.in_width;
	assign wh_sat = ({1'b0, cfg.window_height} > WIN_CNT_W'(MAX_WINDOW)) ?
		WIN_CNT_W'(MAX_WINDOW) : {1'b0, cfg.window_height};
	assign ww_sat = ({1'b0, cfg.window_width} > WIN_CNT_W'(MAX_WINDOW)) ?
		WIN_CNT_W'(MAX_WINDOW) : {1'b0, cfg.window_width};

	assign row_pos = r0_q + POS_W'(i_q);
	assign col_pos = c0_q + POS_W'(j_q);

	assign pos_ok = chan_ok_q && (wh_sat != '0) && (ww_sat != '0)
		&& !row_pos[POS_W-1] && (row_pos < POS_W'(hsat))
		&& !col_pos[POS_W-1] && (col_pos < POS_W'(wsat));

	assign j_last   = (WIN_CNT_W'(j_q) + WIN_CNT_W'(1)) >= ww_sat;
	assign last_pos = j_last && ((WIN_CNT_W'(i_q) + WIN_CNT_W'(1)) >= wh_sat);

	assign och8    = {4'b0000, och_q};
	assign rd_addr = {row_pos[RW-1:0], col_pos[CW-1:0], och8[HW-1:0]};

	assign greater = rd_ok_s1 && ($signed(rd_data) > best_q);

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (func == FUNC_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (last_pos) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_ok_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_ok_s1 <= rd_en && pos_ok;
			last_s1  <= rd_en && last_pos;
			done_q   <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_QUERY)) begin
			r0_q      <= POS_W'(out_row) * POS_W'(cfg.step_rows) - POS_W'(cfg.pad_rows);
			c0_q      <= POS_W'(out_col) * POS_W'(cfg.step_cols) - POS_W'(cfg.pad_cols);
			och_q     <= out_channel;
			chan_ok_q <= 9'(out_channel) < 9'(MAX_CHANNELS);
			i_q       <= '0;
			j_q       <= '0;
			best_q    <= MAX_FLOOR;
		end else begin
			if (rd_en) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + WI'(1);
				end else begin
					j_q <= j_q + WI'(1);
				end
			end
			if (greater) begin
				best_q <= $signed(rd_data);
			end
		end
		if (last_s1) begin
			max_q <= greater ? $signed(rd_data) : best_q;
		end
	end

	assign done      = done_q;
	assign max_value = max_q;

endmodule
